// ----- rtl/mpbf_pkg.sv -----
// Shared constants, types and codes for the multi-pipe byte FIFO.
package mpbf_pkg;
	localparam int PIPE_COUNT = 64;
	localparam int PIPE_DEPTH = 4096;
	localparam int IDX_W = $clog2(PIPE_COUNT);
	localparam int PTR_W = $clog2(PIPE_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int ADDR_W = IDX_W + PTR_W;
	localparam int ALLOC_PIPES = (PIPE_COUNT < 64) ? PIPE_COUNT : 64;
	localparam logic [12:0] COUNT_MAX = 13'd8191;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_CLOSE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_BUSY = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_EOF = 3'd4;

	// request as queued between front and back
	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] handle;
		logic [7:0] byte_in;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  byte_out;
		logic [6:0]  read_handle;
		logic [6:0]  write_handle;
		logic [12:0] moved_count;
	} rsp_t;
endpackage

// ----- rtl/mpbf_req_queue.sv -----
// Two-entry request queue between the front end and the pipe engine.
module mpbf_req_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mpbf_pkg::req_t  in_req,
	output logic            out_valid,
	input  logic            out_ready,
	output mpbf_pkg::req_t  out_req
);
	mpbf_pkg::req_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/mpbf_engine.sv -----
// Pipe engine: per-pipe state, byte store and response register.
module mpbf_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mpbf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mpbf_pkg::rsp_t  rsp
);
	localparam int N = mpbf_pkg::PIPE_COUNT;
	localparam int IW = mpbf_pkg::IDX_W;
	localparam int PW = mpbf_pkg::PTR_W;
	localparam int CW = mpbf_pkg::CNT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	typedef struct packed {
		logic [PW-1:0] head;
		logic [PW-1:0] tail;
		logic [CW-1:0] fill;
	} ptr_t;

	logic [7:0] store [2**mpbf_pkg::ADDR_W];
	ptr_t ptr_mem [N];
	logic [N-1:0] valid_q, wclosed_q, rclosed_q;
	logic [12:0] xfer_q;
	logic [1:0] state_q;

	mpbf_pkg::req_t req_s1;
	ptr_t ptr_s1;
	mpbf_pkg::rsp_t rsp_s2;
	logic is_rd_s2;
	logic [7:0] rd_data_s2;
	logic out_valid_q;
	mpbf_pkg::rsp_t out_q;

	logic take, exec, out_free, done_move;
	logic [IW-1:0] idx;
	logic idx_ok, wend, ok_pipe;
	logic [IW-1:0] free_idx;
	logic free_found;
	mpbf_pkg::rsp_t r;
	mpbf_pkg::rsp_t done_rsp;
	logic do_wr, do_rd, do_create, do_close;
	logic [12:0] xfer_inc;
	ptr_t ptr_next;

	// one request at a time: take, execute, hand to the output register
	assign req_ready = (state_q == S_IDLE);
	assign take = req_valid && req_ready;
	assign exec = (state_q == S_EXEC);
	assign out_free = !out_valid_q || rsp_ready;
	assign done_move = (state_q == S_DONE) && out_free;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	assign idx_ok = ({1'b0, req_s1.handle[6:1]} < 7'(N));
	assign idx = IW'(req_s1.handle[6:1]);
	assign wend = req_s1.handle[0];
	assign ok_pipe = idx_ok && valid_q[idx];
	assign xfer_inc = (xfer_q < mpbf_pkg::COUNT_MAX) ? xfer_q + 13'd1 : xfer_q;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = mpbf_pkg::ALLOC_PIPES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		r = '0;
		do_wr = 1'b0;
		do_rd = 1'b0;
		do_create = 1'b0;
		do_close = 1'b0;
		case (req_s1.cmd)
			mpbf_pkg::CMD_CREATE: begin
				if (free_found) begin
					do_create = 1'b1;
					r.read_handle = {free_idx, 1'b0};
					r.write_handle = {free_idx, 1'b1};
				end else begin
					r.status = mpbf_pkg::ST_BUSY;
				end
			end
			mpbf_pkg::CMD_WRITE: begin
				if (!ok_pipe || !wend || wclosed_q[idx]) r.status = mpbf_pkg::ST_INVALID;
				else if (ptr_s1.fill >= CW'(mpbf_pkg::PIPE_DEPTH)) r.status = mpbf_pkg::ST_BUSY;
				else do_wr = 1'b1;
				r.moved_count = do_wr ? xfer_inc : xfer_q;
			end
			mpbf_pkg::CMD_READ: begin
				if (!ok_pipe || wend || rclosed_q[idx]) r.status = mpbf_pkg::ST_INVALID;
				else if (ptr_s1.fill == '0)
					r.status = wclosed_q[idx] ? mpbf_pkg::ST_EOF : mpbf_pkg::ST_EMPTY;
				else do_rd = 1'b1;
				r.moved_count = do_rd ? xfer_inc : xfer_q;
			end
			default: begin
				if (!ok_pipe) r.status = mpbf_pkg::ST_INVALID;
				else do_close = 1'b1;
			end
		endcase
	end

	always_comb begin
		ptr_next = ptr_s1;
		if (do_wr) begin
			ptr_next.tail = (ptr_s1.tail == PW'(mpbf_pkg::PIPE_DEPTH - 1)) ? '0
				: ptr_s1.tail + PW'(1);
			ptr_next.fill = ptr_s1.fill + CW'(1);
		end
		if (do_rd) begin
			ptr_next.head = (ptr_s1.head == PW'(mpbf_pkg::PIPE_DEPTH - 1)) ? '0
				: ptr_s1.head + PW'(1);
			ptr_next.fill = ptr_s1.fill - CW'(1);
		end
	end

	always_comb begin
		done_rsp = rsp_s2;
		if (is_rd_s2) done_rsp.byte_out = rd_data_s2;
	end

	// pointer table and store: registered reads, one write each per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
			ptr_s1 <= ptr_mem[IW'(req.handle[6:1])];
		end
		if (exec && do_create) ptr_mem[free_idx] <= '0;
		if (exec && (do_wr || do_rd)) ptr_mem[idx] <= ptr_next;
		if (exec && do_wr) store[{idx, ptr_s1.tail}] <= req_s1.byte_in;
		if (exec && do_rd) rd_data_s2 <= store[{idx, ptr_s1.head}];
		if (exec) begin
			rsp_s2 <= r;
			is_rd_s2 <= do_rd;
		end
		if (done_move) out_q <= done_rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			wclosed_q <= '0;
			rclosed_q <= '0;
			xfer_q <= '0;
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done_move) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
			if (exec) begin
				if (do_create) begin
					valid_q[free_idx] <= 1'b1;
					wclosed_q[free_idx] <= 1'b0;
					rclosed_q[free_idx] <= 1'b0;
				end
				if (do_close) begin
					if (wend) wclosed_q[idx] <= 1'b1;
					else rclosed_q[idx] <= 1'b1;
					if ((wend || wclosed_q[idx]) && (!wend || rclosed_q[idx]))
						valid_q[idx] <= 1'b0;
				end
				if (req_s1.last_byte) xfer_q <= '0;
				else if (do_wr || do_rd) xfer_q <= xfer_inc;
			end
		end
	end
endmodule

// ----- rtl/multi_pipe_byte_fifo.sv -----
// Top level of the multi-pipe byte FIFO.
// A request passes the queue pop with pointer lookup, the pointer update with store
// access, and then the output register.
// The engine runs one request at a time and takes no new one before the last has moved
// to the output register; a stalled result holds it while the queue takes two more requests.
// Reset: arst_n clears pipe flags and the transfer count; store and pointers have no reset.
module multi_pipe_byte_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [6:0]  handle,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  byte_out,
	output logic [6:0]  read_handle,
	output logic [6:0]  write_handle,
	output logic [12:0] moved_count
);
	mpbf_pkg::req_t in_req, q_req;
	mpbf_pkg::rsp_t rsp;
	logic q_valid, q_ready;

	// front: pack the request into the queue
	assign in_req = '{cmd: cmd, handle: handle, byte_in: byte_in, last_byte: last_byte};

	mpbf_req_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	// back: pipe state and store; a pipe's pointers are cleared on create
	mpbf_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(rsp)
	);

	assign status = rsp.status;
	assign byte_out = rsp.byte_out;
	assign read_handle = rsp.read_handle;
	assign write_handle = rsp.write_handle;
	assign moved_count = rsp.moved_count;
endmodule

// ----- rtl/mpbf_checker.sv -----
// Port checker for the multi-pipe byte FIFO, bound to the top level.
module mpbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [7:0]  byte_out,
	input logic [6:0]  read_handle,
	input logic [6:0]  write_handle
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped or changed while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= mpbf_pkg::ST_EOF)
		else $error("status out of range");
	a_handle_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_handle != '0 |-> write_handle == (read_handle | 7'd1))
		else $error("handle pair mismatch");
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mpbf_pkg::ST_OK |-> byte_out == '0)
		else $error("byte on failed request");
endmodule

bind multi_pipe_byte_fifo mpbf_checker u_mpbf_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .byte_out(byte_out), .read_handle(read_handle),
	.write_handle(write_handle)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the multi-pipe byte FIFO: random requests against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Predicts one result per request and keeps them in order until they come out.
	class pipe_scoreboard;
		logic [7:0]      store [int];
		int              head [mpbf_pkg::PIPE_COUNT];
		int              tail [mpbf_pkg::PIPE_COUNT];
		int              fill [mpbf_pkg::PIPE_COUNT];
		bit              live [mpbf_pkg::PIPE_COUNT];
		bit              wr_closed [mpbf_pkg::PIPE_COUNT];
		bit              rd_closed [mpbf_pkg::PIPE_COUNT];
		int              xfer;
		mpbf_pkg::rsp_t  pending [$];
		int              mismatches;

		function void clear();
			foreach (head[i]) begin
				head[i] = 0; tail[i] = 0; fill[i] = 0;
				live[i] = 0; wr_closed[i] = 0; rd_closed[i] = 0;
			end
			xfer = 0;
			mismatches = 0;
			pending.delete();
		endfunction

		function void note_request(mpbf_pkg::req_t r);
			mpbf_pkg::rsp_t e;
			int idx;
			bit wend;
			bit okp;
			idx = r.handle >> 1;
			wend = r.handle[0];
			okp = (idx < mpbf_pkg::PIPE_COUNT) && live[idx];
			e = '0;
			case (r.cmd)
				mpbf_pkg::CMD_CREATE: begin
					e.status = mpbf_pkg::ST_BUSY;
					for (int i = 0; i < mpbf_pkg::ALLOC_PIPES; i++) begin
						if (!live[i]) begin
							head[i] = 0; tail[i] = 0; fill[i] = 0;
							live[i] = 1; wr_closed[i] = 0; rd_closed[i] = 0;
							e.read_handle = 7'(2 * i);
							e.write_handle = 7'(2 * i + 1);
							e.status = mpbf_pkg::ST_OK;
							break;
						end
					end
				end
				mpbf_pkg::CMD_WRITE: begin
					if (!okp || !wend || wr_closed[idx]) e.status = mpbf_pkg::ST_INVALID;
					else if (fill[idx] >= mpbf_pkg::PIPE_DEPTH) e.status = mpbf_pkg::ST_BUSY;
					else begin
						store[idx * mpbf_pkg::PIPE_DEPTH + tail[idx]] = r.byte_in;
						tail[idx] = (tail[idx] + 1) % mpbf_pkg::PIPE_DEPTH;
						fill[idx]++;
						if (xfer < mpbf_pkg::COUNT_MAX) xfer++;
					end
					e.moved_count = 13'(xfer);
				end
				mpbf_pkg::CMD_READ: begin
					if (!okp || wend || rd_closed[idx]) e.status = mpbf_pkg::ST_INVALID;
					else if (fill[idx] == 0)
						e.status = wr_closed[idx] ? mpbf_pkg::ST_EOF : mpbf_pkg::ST_EMPTY;
					else begin
						e.byte_out = store[idx * mpbf_pkg::PIPE_DEPTH + head[idx]];
						head[idx] = (head[idx] + 1) % mpbf_pkg::PIPE_DEPTH;
						fill[idx]--;
						if (xfer < mpbf_pkg::COUNT_MAX) xfer++;
					end
					e.moved_count = 13'(xfer);
				end
				default: begin
					if (!okp) e.status = mpbf_pkg::ST_INVALID;
					else begin
						if (wend) wr_closed[idx] = 1;
						else rd_closed[idx] = 1;
						if (wr_closed[idx] && rd_closed[idx]) live[idx] = 0;
					end
				end
			endcase
			if (r.last_byte) xfer = 0;
			pending.push_back(e);
		endfunction

		function void check_result(mpbf_pkg::rsp_t a);
			mpbf_pkg::rsp_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", a);
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status || a.byte_out !== e.byte_out
					|| a.read_handle !== e.read_handle || a.write_handle !== e.write_handle
					|| a.moved_count !== e.moved_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", e, a);
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLDOFF_CYCLES = 300;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [6:0]  handle = '0;
	logic [7:0]  byte_in = '0;
	logic        last_byte = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic [7:0]  byte_out;
	logic [6:0]  read_handle;
	logic [6:0]  write_handle;
	logic [12:0] moved_count;

	pipe_scoreboard sb = new();
	int send_idle_pct = 0;   // chance of a gap before each request
	int recv_stall_pct = 0;  // chance of out_ready low in a cycle
	bit holdoff = 0;         // long receiver hold-off in progress
	int quiet_cycles = 0;
	int handle_pool [$];     // handles of pipes created so far

	multi_pipe_byte_fifo uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: random stalls, or a long hold-off when asked for.
	always @(posedge clk) begin
		if (holdoff) out_ready <= 0;
		else out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status, byte_out, read_handle, write_handle, moved_count});
	end

	// Watchdog: counts cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one request and hold it until accepted; valid stays up for the next one.
	task send_request(input logic [1:0] c, input logic [6:0] h, input logic [7:0] b,
			input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c; handle <= h; byte_in <= b; last_byte <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_request('{c, h, b, l});
	endtask

	task drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function logic [6:0] pick_handle();
		if (handle_pool.size() != 0 && $urandom_range(9) < 8)
			return 7'(handle_pool[$urandom_range(handle_pool.size() - 1)] ^ $urandom_range(1));
		return 7'($urandom_range(127));
	endfunction

	// A session: an optional create, a transfer call of writes, maybe a writer close, reads, an optional close.
	task pipe_session();
		int n;
		logic [6:0] rh;
		bit own;
		rh = 7'(2 * $urandom_range(mpbf_pkg::ALLOC_PIPES - 1));
		own = 0;
		if ($urandom_range(3) != 0) begin
			send_request(mpbf_pkg::CMD_CREATE, 7'($urandom_range(127)),
				8'($urandom_range(255)), 0);
			// find the handle the predictor just handed out
			if (sb.pending[$].status == mpbf_pkg::ST_OK) begin
				rh = sb.pending[$].read_handle;
				handle_pool.push_back(rh);
				own = 1;
			end
		end
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			send_request(mpbf_pkg::CMD_WRITE, rh | 7'd1, 8'($urandom_range(255)), i == n - 1);
		if ($urandom_range(2) == 0)
			send_request(mpbf_pkg::CMD_CLOSE, rh | 7'd1, 8'($urandom_range(255)),
				1'($urandom_range(1)));
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++)
			send_request(mpbf_pkg::CMD_READ, rh, 8'($urandom_range(255)), i == n - 1);
		if (own && $urandom_range(1)) begin
			send_request(mpbf_pkg::CMD_CLOSE, rh, 8'($urandom_range(255)), 0);
			send_request(mpbf_pkg::CMD_CLOSE, rh | 7'd1, 8'($urandom_range(255)), 0);
		end
	endtask

	task random_phase(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) < 7) begin
				pipe_session();
				sent += 12;
			end else begin
				send_request(2'($urandom_range(3)), pick_handle(), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: bad handles on a fresh block, then one pipe end to end.
		send_request(mpbf_pkg::CMD_WRITE, 7'd127, 8'hff, 0);
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 0);
		send_request(mpbf_pkg::CMD_CLOSE, 7'd1, 8'h00, 1);
		send_request(mpbf_pkg::CMD_CREATE, 7'd0, 8'h00, 0);
		send_request(mpbf_pkg::CMD_WRITE, 7'd0, 8'h55, 0);   // write on read end
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 0);    // empty
		send_request(mpbf_pkg::CMD_WRITE, 7'd1, 8'h00, 0);
		send_request(mpbf_pkg::CMD_WRITE, 7'd1, 8'hff, 1);
		send_request(mpbf_pkg::CMD_READ, 7'd1, 8'h00, 0);    // read on write end
		send_request(mpbf_pkg::CMD_CLOSE, 7'd1, 8'h00, 0);
		send_request(mpbf_pkg::CMD_CLOSE, 7'd1, 8'h00, 0);   // already closed is fine
		send_request(mpbf_pkg::CMD_WRITE, 7'd1, 8'haa, 0);   // write after writer closed
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 0);
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 0);
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 1);    // end of file
		send_request(mpbf_pkg::CMD_CLOSE, 7'd0, 8'h00, 0);   // frees pipe 0
		send_request(mpbf_pkg::CMD_READ, 7'd0, 8'h00, 0);    // freed pipe now invalid
		drain();

		// Exhaust every pipe, then one more create must report busy.
		for (int i = 0; i <= mpbf_pkg::ALLOC_PIPES; i++)
			send_request(mpbf_pkg::CMD_CREATE, 7'd0, 8'h00, 0);
		for (int i = 0; i < mpbf_pkg::ALLOC_PIPES; i++) begin
			send_request(mpbf_pkg::CMD_CLOSE, 7'(2 * i), 8'h00, 0);
			send_request(mpbf_pkg::CMD_CLOSE, 7'(2 * i + 1), 8'h00, 0);
		end
		drain();

		// Random phases under varied idling.
		send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(400);
		send_idle_pct = 85; recv_stall_pct = 0;  random_phase(300);
		drain();  // sender waits out every result
		send_idle_pct = 0;  recv_stall_pct = 85; random_phase(300);
		send_idle_pct = 22; recv_stall_pct = 22; random_phase(300);

		// Long receiver hold-off while requests keep coming, to back up the input.
		send_idle_pct = 0; recv_stall_pct = 0;
		fork
			begin
				holdoff = 1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff = 0;
			end
			begin
				random_phase(300);
				drain();
			end
		join

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
